/* rtl/josephus_elimination_order_unit_macros.svh */
// assertion helpers for the josephus elimination order unit
`ifndef JOSEPHUS_ELIMINATION_ORDER_UNIT_MACROS_SVH
`define JOSEPHUS_ELIMINATION_ORDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define JEO_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define JEO_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JEO_ASSERT_IMPL(name, clk, rstn, ante, cons, msg)
`define JEO_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)
`endif

`endif

/* rtl/jeo_pkg.sv */
`default_nettype none

package jeo_pkg;

    // field widths of the streams
    localparam int NUM_PEOPLE_W = 7;
    localparam int STEP_W       = 8;
    localparam int START_W      = 8;
    localparam int LABEL_W      = 7;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 8;

    // per-cycle command broadcast to every ring cell
    typedef struct packed {
        logic load;
        logic rotate;
        logic pop;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/jeo_ring_cell.sv */
`default_nettype none

module jeo_ring_cell #(
    parameter int LBL_W      = 7,
    parameter int CELL_INDEX = 0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  jeo_pkg::cell_ctl_t  ctl,
    input  wire  [LBL_W-1:0]    ring_len,
    input  wire  [LBL_W-1:0]    head_label,
    input  wire  [LBL_W-1:0]    nxt_label,
    input  wire                 nxt_valid,
    output logic [LBL_W-1:0]    label_o,
    output logic                valid_o
);

    logic [LBL_W-1:0] label_reg;
    logic [LBL_W-1:0] label_next;
    logic             valid_reg;
    logic             valid_next;

    always_comb begin
        label_next = label_reg;
        valid_next = valid_reg;
        if (ctl.load) begin
            valid_next = (LBL_W'(CELL_INDEX) < ring_len);
            label_next = LBL_W'(CELL_INDEX + 1);
        end else if (ctl.pop) begin
            label_next = nxt_label;
            valid_next = nxt_valid;
        end else if (ctl.rotate) begin
            // the last occupied cell wraps around to the head
            label_next = nxt_valid ? nxt_label : head_label;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        label_reg <= label_next;
    end

    assign label_o = label_reg;
    assign valid_o = valid_reg;

endmodule

`default_nettype wire

/* rtl/josephus_elimination_order_unit.sv */
// josephus elimination order unit
//
// input channel s_*: one item per run, tdata = {start_pos[22:15], step[14:7],
// num_people[6:0]}; s_tready is high only while no run is in progress.
// output channel m_*: one item per person, label in tdata[6:0]; the survivor
// comes last with m_tlast set. a run of n people gives n items.
// a count of zero starts no run, a count above MAX_PEOPLE is saturated, a
// step of zero acts as one and a start of zero selects person n.
// the ring is a row of MAX_PEOPLE cells that shift by one position a cycle while rotating;
// the head cell is always the person counted next.
// sequence: a load, then alignment rotations up to the start position (to
// person n for a start of zero), then for each removed person step - 1
// rotations, one count check and one emit, and a count check and an emit
// for the survivor, the single-position rotation of the cell row setting
// the pace.
// the result sits in an output register; while m_tready is low the ring
// freezes at the emit point and nothing is lost or repeated.
// synchronous active-low reset empties the ring and drops any pending item.
`default_nettype none
`include "josephus_elimination_order_unit_macros.svh"

module josephus_elimination_order_unit #(
    parameter int MAX_PEOPLE = 64
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // num_people[6:0], step[14:7], start_pos[22:15], zero pad
    input  wire  [jeo_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // label[6:0], zero pad
    output logic [jeo_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire                                  m_tready
);

    // ring counts and labels share one width
    localparam int CNT_W = $clog2(MAX_PEOPLE + 1);
    localparam int CMP_W = (CNT_W > jeo_pkg::NUM_PEOPLE_W) ? CNT_W : jeo_pkg::NUM_PEOPLE_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ALIGN = 4'b0010,
        ST_SKIP  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [jeo_pkg::STEP_W-1:0]  rot_cnt_reg, rot_cnt_next;
    logic [jeo_pkg::STEP_W-1:0]  step_m1_reg, step_m1_next;
    logic [CNT_W-1:0]            rem_reg, rem_next;
    logic                        m_valid_reg, m_valid_next;
    logic [jeo_pkg::LABEL_W-1:0] m_label_reg, m_label_next;
    logic                        m_last_reg, m_last_next;

    // input field unpacking
    logic [jeo_pkg::NUM_PEOPLE_W-1:0] in_num;
    logic [jeo_pkg::STEP_W-1:0]       in_step;
    logic [jeo_pkg::START_W-1:0]      in_start;
    logic [CMP_W-1:0]                 n_wide;
    logic [CMP_W-1:0]                 n_sat;
    logic [CNT_W-1:0]                 n_eff;
    logic [jeo_pkg::STEP_W-1:0]       align_cnt;

    assign in_num   = s_tdata[jeo_pkg::NUM_PEOPLE_W-1:0];
    assign in_step  = s_tdata[jeo_pkg::NUM_PEOPLE_W +: jeo_pkg::STEP_W];
    assign in_start = s_tdata[jeo_pkg::NUM_PEOPLE_W + jeo_pkg::STEP_W +: jeo_pkg::START_W];

    assign n_wide = CMP_W'(in_num);
    assign n_sat  = (n_wide > CMP_W'(MAX_PEOPLE)) ? CMP_W'(MAX_PEOPLE) : n_wide;
    assign n_eff  = CNT_W'(n_sat);
    // start of zero selects the last person
    assign align_cnt = (in_start == '0) ? jeo_pkg::STEP_W'(n_sat - CMP_W'(1))
                                        : in_start - jeo_pkg::STEP_W'(1);

    // cell row
    jeo_pkg::cell_ctl_t ctl;
    logic [CNT_W-1:0]   cell_label [MAX_PEOPLE];
    logic [MAX_PEOPLE-1:0] cell_valid;
    logic [CNT_W-1:0]   head_label;

    assign head_label = cell_label[0];

    for (genvar gi = 0; gi < MAX_PEOPLE; gi++) begin : g_cell
        logic [CNT_W-1:0] nxt_label;
        logic             nxt_valid;
        if (gi == MAX_PEOPLE - 1) begin : g_end
            assign nxt_label = head_label;
            assign nxt_valid = 1'b0;
        end else begin : g_mid
            assign nxt_label = cell_label[gi+1];
            assign nxt_valid = cell_valid[gi+1];
        end
        jeo_ring_cell #(
            .LBL_W      (CNT_W),
            .CELL_INDEX (gi)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .ring_len   (n_eff),
            .head_label (head_label),
            .nxt_label  (nxt_label),
            .nxt_valid  (nxt_valid),
            .label_o    (cell_label[gi]),
            .valid_o    (cell_valid[gi])
        );
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        rot_cnt_next = rot_cnt_reg;
        step_m1_next = step_m1_reg;
        rem_next     = rem_reg;
        m_label_next = m_label_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        ctl          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (in_num != '0)) begin
                    ctl.load     = 1'b1;
                    rem_next     = n_eff;
                    rot_cnt_next = align_cnt;
                    step_m1_next = (in_step == '0) ? '0 : in_step - jeo_pkg::STEP_W'(1);
                    state_next   = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (rot_cnt_reg == '0) begin
                    rot_cnt_next = step_m1_reg;
                    state_next   = ST_SKIP;
                end else begin
                    ctl.rotate   = 1'b1;
                    rot_cnt_next = rot_cnt_reg - jeo_pkg::STEP_W'(1);
                end
            end
            ST_SKIP: begin
                if ((rot_cnt_reg == '0) || (rem_reg == CNT_W'(1))) begin
                    state_next = ST_EMIT;
                end else begin
                    ctl.rotate   = 1'b1;
                    rot_cnt_next = rot_cnt_reg - jeo_pkg::STEP_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_label_next = jeo_pkg::LABEL_W'(head_label);
                    m_last_next  = (rem_reg == CNT_W'(1));
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        ctl.pop      = 1'b1;
                        rem_next     = rem_reg - CNT_W'(1);
                        rot_cnt_next = step_m1_reg;
                        state_next   = ST_SKIP;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rem_reg     <= '0;
            rot_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rem_reg     <= rem_next;
            rot_cnt_reg <= rot_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        step_m1_reg <= step_m1_next;
        m_label_reg <= m_label_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = jeo_pkg::OUT_TDATA_W'(m_label_reg);

    // occupied cells always match the people count during a run
    `JEO_ASSERT_IMPL(a_count_match, aclk, aresetn, state_reg != ST_IDLE, $countones(cell_valid) == rem_reg, "ring occupancy differs from people count")
    // the head cell holds a person whenever a run is active
    `JEO_ASSERT_IMPL(a_head_valid, aclk, aresetn, state_reg != ST_IDLE, cell_valid[0] && (rem_reg != '0), "empty ring head during a run")
    // emitting the survivor ends the run
    `JEO_ASSERT_NEXT(a_survivor_ends, aclk, aresetn, (state_reg == ST_EMIT) && out_free && (rem_reg == CNT_W'(1)), (state_reg == ST_IDLE) && m_tvalid && m_tlast, "survivor emit did not end the run")
    // a non-final emit never sets the last flag
    `JEO_ASSERT_NEXT(a_no_early_last, aclk, aresetn, (state_reg == ST_EMIT) && out_free && (rem_reg != CNT_W'(1)), m_tvalid && !m_tlast, "last flag on a removal")

endmodule

`default_nettype wire
